// File: hw/rtl/ptti_pkg.sv
// ----------------------------------------------------------------------------
// ptti_pkg: shared types and constants for the page table
// Word layouts of the item, result and configuration channels, status and
// opcode codes, register indexes and default table sizes.
// ----------------------------------------------------------------------------
package ptti_pkg;

  localparam int unsigned MaxPagesDef = 1024;
  localparam int unsigned MaxSlotsDef = 256;

  localparam int unsigned PageOffW = 16;
  localparam int unsigned CmpW     = 17;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SLOT  = 2'd3
  } status_e;

  typedef enum logic {
    OP_TRANSLATE = 1'b0,
    OP_INSTALL   = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    REG_PAGING_MODE = 2'd0,
    REG_PAGE_COUNT  = 2'd1,
    REG_SLOT_COUNT  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic        opcode;
    logic [25:0] byte_offset;
    logic [15:0] target_page;
    logic [15:0] chosen_slot;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [25:0] window_offset;
    logic [9:0]  miss_page;
    logic [9:0]  result_slot;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [10:0] data;
  } cfg_word_t;

  // Address width for a table of the given depth, at least one bit.
  function automatic int unsigned idx_width(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// File: hw/rtl/ptti_if.sv
// ----------------------------------------------------------------------------
// ptti_if: valid/ready channels of the page table
// Item, result and configuration channels, each with a source and sink view.
// ----------------------------------------------------------------------------
interface ptti_in_if;
  logic               valid;
  logic               ready;
  ptti_pkg::in_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ptti_out_if;
  logic                valid;
  logic                ready;
  ptti_pkg::out_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ptti_cfg_if;
  logic                valid;
  logic                ready;
  ptti_pkg::cfg_word_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/ptti_ram.sv
// ----------------------------------------------------------------------------
// ptti_ram: single-port-write, single-port-read synchronous memory
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ptti_ram #(
  parameter int unsigned Depth = ptti_pkg::MaxPagesDef,
  parameter int unsigned Width = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [ptti_pkg::idx_width(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [ptti_pkg::idx_width(Depth)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/page_table_translate_and_install.sv
// ----------------------------------------------------------------------------
// page_table_translate_and_install: demand-paging page table
// Forward (page to slot) and reverse (slot to page) maps held in two
// synchronous memories, with translate and install operations.
// ----------------------------------------------------------------------------
// Usage. Items arrive on in_i, one word per item: a translate word looks up
// the page in bits 25..16 of byte_offset; in paging mode an install word
// maps target_page onto chosen_slot and evicts the slot's old page. Every item
// yields exactly one result word on out_o, in order. Configuration words on
// cfg_i set the mode and the page and slot counts; the port is always ready
// and must only be written while no item is in flight.
// Sequence. The map read is issued on the edge that accepts the word, which
// moves the sequencer to S_LOOK. A translate word, and any word that writes
// no map, goes to the result register from S_LOOK once it is free; in_i is
// ready again back in S_IDLE. An install in paging mode with a valid slot
// uses the single write port of the forward map for the victim, if any, in
// S_LOOK, then for its own entry in S_INST with the reverse write; its result
// is registered there once the output register is free. Only one item is in
// flight at a time.
// Reset. After rst_ni is released a clearing pass over max(MaxPages, MaxSlots)
// addresses (1024 at the default sizes) marks every map entry invalid; in_i is
// not ready during the pass. Configuration registers reset to zero.
// Stall. The result sits in an output register; when the receiver stalls, the
// block takes at most one more item and holds it until the word is taken.
// ----------------------------------------------------------------------------
module page_table_translate_and_install #(
  parameter int unsigned MaxPages = ptti_pkg::MaxPagesDef,
  parameter int unsigned MaxSlots = ptti_pkg::MaxSlotsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  ptti_in_if.sink       in_i,
  ptti_out_if.source    out_o,
  ptti_cfg_if.sink      cfg_i
);

  localparam int unsigned PageIdxW = ptti_pkg::idx_width(MaxPages);
  localparam int unsigned SlotIdxW = ptti_pkg::idx_width(MaxSlots);
  // Each map entry carries a valid flag above the stored index.
  localparam int unsigned FwdW     = SlotIdxW + 1;
  localparam int unsigned RevW     = PageIdxW + 1;
  localparam int unsigned ClrDepth = (MaxPages > MaxSlots) ? MaxPages : MaxSlots;
  localparam int unsigned ClrW     = ptti_pkg::idx_width(ClrDepth);
  localparam int unsigned CmpW     = ptti_pkg::CmpW;

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_INST  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic        mode_q;
  logic [10:0] pages_q;
  logic [8:0]  slots_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      pages_q <= '0;
      slots_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (ptti_pkg::reg_idx_e'(cfg_i.payload.index))
        ptti_pkg::REG_PAGING_MODE: mode_q  <= cfg_i.payload.data[0];
        ptti_pkg::REG_PAGE_COUNT:  pages_q <= cfg_i.payload.data;
        ptti_pkg::REG_SLOT_COUNT:  slots_q <= cfg_i.payload.data[8:0];
        default: ;
      endcase
    end
  end

  // Acceptance and the checks that can be settled from the word itself.
  logic               in_acc;
  logic               acc_install;
  logic [15:0]        acc_page;
  logic               acc_oor;
  logic               acc_slot_bad;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign acc_install = (in_i.payload.opcode == ptti_pkg::OP_INSTALL);
  assign acc_page    = acc_install ? in_i.payload.target_page
                                   : {6'd0, in_i.payload.byte_offset[25:16]};
  // A page is out of range at or above min(register, MaxPages); same for slots.
  assign acc_oor = (CmpW'(acc_page) >= CmpW'(pages_q)) ||
                   (CmpW'(acc_page) >= CmpW'(MaxPages));
  assign acc_slot_bad = (CmpW'(in_i.payload.chosen_slot) >= CmpW'(slots_q)) ||
                        (CmpW'(in_i.payload.chosen_slot) >= CmpW'(MaxSlots));

  // Item held for the rest of its processing; payload needs no reset.
  ptti_pkg::in_word_t item_q;
  logic [15:0]        page_q;
  logic               oor_q;
  logic               slot_bad_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q     <= in_i.payload;
      page_q     <= acc_page;
      oor_q      <= acc_oor;
      slot_bad_q <= acc_slot_bad;
    end
  end

  logic                is_install;
  logic [PageIdxW-1:0] page_idx;
  logic [SlotIdxW-1:0] slot_idx;

  assign is_install = (item_q.opcode == ptti_pkg::OP_INSTALL);
  assign page_idx   = PageIdxW'(page_q);
  assign slot_idx   = SlotIdxW'(item_q.chosen_slot);

  // Clearing pass counter.
  logic [ClrW-1:0] clr_q;
  logic            clr_done;

  assign clr_done = (clr_q == ClrW'(ClrDepth - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (state_q == S_CLEAR && !clr_done) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // Map memories.
  logic                fwd_we, fwd_re;
  logic [PageIdxW-1:0] fwd_waddr;
  logic [FwdW-1:0]     fwd_wdata, fwd_rdata;
  logic                rev_we, rev_re;
  logic [SlotIdxW-1:0] rev_waddr;
  logic [RevW-1:0]     rev_wdata, rev_rdata;

  ptti_ram #(
    .Depth (MaxPages),
    .Width (FwdW)
  ) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (fwd_we),
    .waddr_i (fwd_waddr),
    .wdata_i (fwd_wdata),
    .re_i    (fwd_re),
    .raddr_i (PageIdxW'(acc_page)),
    .rdata_o (fwd_rdata)
  );

  ptti_ram #(
    .Depth (MaxSlots),
    .Width (RevW)
  ) u_rev_ram (
    .clk_i   (clk_i),
    .we_i    (rev_we),
    .waddr_i (rev_waddr),
    .wdata_i (rev_wdata),
    .re_i    (rev_re),
    .raddr_i (SlotIdxW'(in_i.payload.chosen_slot)),
    .rdata_o (rev_rdata)
  );

  // Reads are only issued for in-range items in paging mode, so the read
  // address always lies inside the table. The read register then holds until
  // the next read is issued.
  assign fwd_re = in_acc && !acc_install && mode_q && !acc_oor;
  assign rev_re = in_acc && acc_install && mode_q && !acc_oor && !acc_slot_bad;

  // An in-range install in paging mode with a valid slot needs the S_INST state.
  logic need_inst;
  logic victim_kill;
  logic out_free;
  logic emit;

  assign need_inst = is_install && mode_q && !oor_q && !slot_bad_q;
  // The slot's previous owner loses its forward entry unless it is the page
  // being installed.
  assign victim_kill = rev_rdata[RevW-1] && (rev_rdata[PageIdxW-1:0] != page_idx);
  assign out_free = !out_o.valid || out_o.ready;
  assign emit     = ((state_q == S_LOOK && !need_inst) || state_q == S_INST) && out_free;

  always_comb begin
    fwd_we    = 1'b0;
    fwd_waddr = page_idx;
    fwd_wdata = {1'b1, slot_idx};
    rev_we    = 1'b0;
    rev_waddr = slot_idx;
    rev_wdata = {1'b1, page_idx};
    unique case (state_q)
      S_CLEAR: begin
        fwd_we    = (32'(clr_q) < MaxPages);
        fwd_waddr = PageIdxW'(clr_q);
        fwd_wdata = '0;
        rev_we    = (32'(clr_q) < MaxSlots);
        rev_waddr = SlotIdxW'(clr_q);
        rev_wdata = '0;
      end
      S_LOOK: begin
        fwd_we    = need_inst && victim_kill;
        fwd_waddr = rev_rdata[PageIdxW-1:0];
        fwd_wdata = '0;
      end
      S_INST: begin
        fwd_we = emit;
        rev_we = emit;
      end
      default: ;
    endcase
  end

  // Result word.
  ptti_pkg::out_word_t res;
  logic [31:0]         slot32;
  logic [31:0]         win32;

  assign slot32 = 32'(fwd_rdata[SlotIdxW-1:0]);
  assign win32  = (slot32 << ptti_pkg::PageOffW) | 32'(item_q.byte_offset[15:0]);

  always_comb begin
    res               = '0;
    res.miss_page     = page_q[9:0];
    res.status        = ptti_pkg::ST_OK;
    if (oor_q) begin
      res.status = ptti_pkg::ST_RANGE;
    end else if (!mode_q) begin
      // Identity mapping: a page is its own slot.
      res.result_slot = page_q[9:0];
      if (!is_install) begin
        res.window_offset = item_q.byte_offset;
      end
    end else if (!is_install) begin
      if (!fwd_rdata[FwdW-1]) begin
        res.status = ptti_pkg::ST_MISS;
      end else begin
        res.window_offset = win32[25:0];
        res.result_slot   = slot32[9:0];
      end
    end else if (slot_bad_q) begin
      res.status = ptti_pkg::ST_SLOT;
    end else begin
      res.result_slot = item_q.chosen_slot[9:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_done) state_d = S_IDLE;
      S_IDLE:  if (in_acc) state_d = S_LOOK;
      S_LOOK: begin
        if (need_inst) begin
          state_d = S_INST;
        end else if (emit) begin
          state_d = S_IDLE;
        end
      end
      S_INST:  if (emit) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register.
  logic                out_valid_q;
  ptti_pkg::out_word_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Checks.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> (!out_valid_q || out_o.ready))
    else $error("result written over a word that was not taken");

  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_LOOK))
    else $error("accepted item did not start its lookup");

  a_inst_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INST && fwd_we) |-> rev_we)
    else $error("install wrote one map without the other");

  a_victim_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK && fwd_we) |-> (fwd_waddr != page_idx))
    else $error("victim invalidation hit the page being installed");

  a_no_read_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> (!fwd_re && !rev_re))
    else $error("map read issued during the clearing pass");

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for page_table_translate_and_install
// Drives translate and install words through the valid/ready channels,
// predicts every result word with a behavioral copy of the page table and
// compares the words field by field. A short directed part covers the
// extremes and the corner cases. A randomized part follows, mostly
// fault-handling flows on a small set of hot pages, under several register
// settings, with random idling on both channels and two long result stalls.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Length of the long result stall. It is far longer than the pipeline, so
  // the block fills up and has to hold its input.
  localparam int unsigned StallCycles = 150;
  localparam int unsigned RandomPhases = 12;
  localparam int unsigned PhaseWords = 42;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ptti_in_if  in_if ();
  ptti_out_if out_if ();
  ptti_cfg_if cfg_if ();

  page_table_translate_and_install dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioral page table. The registers and both maps are mirrored here and
  // advanced once for every word that the block accepts, in order.
  // --------------------------------------------------------------------------
  bit        map_mode;
  bit [10:0] page_limit;
  bit [8:0]  slot_limit;

  bit [8:0] fwd_slot [ptti_pkg::MaxPagesDef];
  bit       fwd_live [ptti_pkg::MaxPagesDef];
  bit [9:0] rev_page [ptti_pkg::MaxSlotsDef];
  bit       rev_live [ptti_pkg::MaxSlotsDef];

  // Results that the block still owes, oldest first.
  ptti_pkg::out_word_t mapping_answers[$];
  ptti_pkg::out_word_t last_answer;

  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned words_sent;
  int unsigned settings_used;
  int unsigned status_tally [4];

  // The sender and the receiver both skip their random idling while steady
  // is set. A stall request makes the receiver hold off for StallCycles.
  bit steady;
  bit stall_request;

  // The page and slot counts in use are the registers clipped to the sizes
  // of the maps.
  function automatic int unsigned pages_in_use();
    return (32'(page_limit) < ptti_pkg::MaxPagesDef) ? 32'(page_limit)
                                                     : ptti_pkg::MaxPagesDef;
  endfunction

  function automatic int unsigned slots_in_use();
    return (32'(slot_limit) < ptti_pkg::MaxSlotsDef) ? 32'(slot_limit)
                                                     : ptti_pkg::MaxSlotsDef;
  endfunction

  // Works out the result word of one accepted word and applies an install to
  // the mirrored maps.
  function automatic ptti_pkg::out_word_t resolve_access(ptti_pkg::in_word_t w);
    ptti_pkg::out_word_t r;
    int unsigned         pg;
    int unsigned         tp;
    int unsigned         cs;
    r = '0;
    if (w.opcode == ptti_pkg::OP_TRANSLATE) begin
      pg = 32'(w.byte_offset[25:16]);
      r.miss_page = pg[9:0];
      if (pg >= pages_in_use()) begin
        r.status = ptti_pkg::ST_RANGE;
      end else if (!map_mode) begin
        r.status        = ptti_pkg::ST_OK;
        r.window_offset = w.byte_offset;
        r.result_slot   = pg[9:0];
      end else if (!fwd_live[pg]) begin
        r.status = ptti_pkg::ST_MISS;
      end else begin
        // A stale slot beyond a lowered slot count is still used as it is.
        r.status        = ptti_pkg::ST_OK;
        r.window_offset = {1'b0, fwd_slot[pg], w.byte_offset[15:0]};
        r.result_slot   = {1'b0, fwd_slot[pg]};
      end
      return r;
    end
    tp = 32'(w.target_page);
    cs = 32'(w.chosen_slot);
    r.miss_page = w.target_page[9:0];
    if (tp >= pages_in_use()) begin
      r.status = ptti_pkg::ST_RANGE;
    end else if (!map_mode) begin
      r.status      = ptti_pkg::ST_OK;
      r.result_slot = w.target_page[9:0];
    end else if (cs >= slots_in_use()) begin
      r.status = ptti_pkg::ST_SLOT;
    end else begin
      // The page that held the slot before loses its forward entry. A page
      // moved elsewhere earlier leaves its old reverse entry behind, so it
      // can lose its new mapping here as well.
      if (rev_live[cs] && rev_page[cs] != tp[9:0]) fwd_live[rev_page[cs]] = 1'b0;
      fwd_slot[tp] = cs[8:0];
      fwd_live[tp] = 1'b1;
      rev_page[cs] = tp[9:0];
      rev_live[cs] = 1'b1;
      r.status      = ptti_pkg::ST_OK;
      r.result_slot = cs[9:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers. Inputs change at the falling edge; handshakes are
  // sampled at the rising edge.
  // --------------------------------------------------------------------------

  // Offers one word, with random idle cycles ahead of it, and records the
  // predicted result once the block takes it.
  task automatic send_access(ptti_pkg::in_word_t w);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 17) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= w;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    last_answer = resolve_access(w);
    mapping_answers.push_back(last_answer);
    status_tally[last_answer.status]++;
    words_sent++;
  endtask

  // Lowers the item valid and waits until every owed result has come back.
  // Every word yields a result, so the block is idle from then on.
  task automatic wait_drained();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (mapping_answers.size() != 0) @(negedge clk_i);
  endtask

  // Writes one register. Now and then the bits above the register's width
  // carry junk, which the block has to drop.
  task automatic write_register(ptti_pkg::reg_idx_e idx, logic [10:0] value);
    ptti_pkg::cfg_word_t w;
    logic [10:0]         keep;
    case (idx)
      ptti_pkg::REG_PAGING_MODE: keep = 11'h001;
      ptti_pkg::REG_SLOT_COUNT:  keep = 11'h1FF;
      default:                   keep = 11'h7FF;
    endcase
    w.index = idx;
    w.data  = value & keep;
    if ($urandom_range(0, 3) == 0) w.data = w.data | (11'($urandom) & ~keep);
    @(negedge clk_i);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= w;
    do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
    case (idx)
      ptti_pkg::REG_PAGING_MODE: map_mode   = w.data[0];
      ptti_pkg::REG_PAGE_COUNT:  page_limit = w.data;
      ptti_pkg::REG_SLOT_COUNT:  slot_limit = w.data[8:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic apply_setting(bit mode, logic [10:0] pages, logic [10:0] slots);
    wait_drained();
    write_register(ptti_pkg::REG_PAGING_MODE, {10'd0, mode});
    write_register(ptti_pkg::REG_PAGE_COUNT, pages);
    write_register(ptti_pkg::REG_SLOT_COUNT, slots);
    settings_used++;
  endtask

  // Word builders. The fields that an operation ignores carry random values.
  function automatic ptti_pkg::in_word_t translate_word(logic [25:0] offset);
    ptti_pkg::in_word_t w;
    w.opcode      = ptti_pkg::OP_TRANSLATE;
    w.byte_offset = offset;
    w.target_page = 16'($urandom);
    w.chosen_slot = 16'($urandom);
    return w;
  endfunction

  function automatic ptti_pkg::in_word_t install_word(logic [15:0] page, logic [15:0] slot);
    ptti_pkg::in_word_t w;
    w.opcode      = ptti_pkg::OP_INSTALL;
    w.byte_offset = 26'($urandom);
    w.target_page = page;
    w.chosen_slot = slot;
    return w;
  endfunction

  // Random word. Most words touch a small set of hot pages, so that hits,
  // misses and victims all come up; some sit right at the page bound, others
  // spread over all pages in range and the rest are plain noise in every field.
  function automatic ptti_pkg::in_word_t random_access();
    ptti_pkg::in_word_t w;
    int unsigned        pages;
    int unsigned        hot;
    int unsigned        pick;
    int unsigned        p;
    w.opcode      = ptti_pkg::opcode_e'($urandom_range(0, 1));
    w.byte_offset = 26'($urandom);
    w.target_page = 16'($urandom);
    w.chosen_slot = 16'($urandom);
    if ($urandom_range(0, 99) < 12) return w;
    pages = pages_in_use();
    hot   = (pages == 0) ? 1 : ((pages < 40) ? pages : 40);
    pick  = $urandom_range(0, 99);
    if (pick < 6) p = pages;
    else if (pick < 85 || pages == 0) p = $urandom_range(0, hot - 1);
    else p = $urandom_range(0, pages - 1);
    w.opcode               = ($urandom_range(0, 99) < 55) ? ptti_pkg::OP_TRANSLATE
                                                          : ptti_pkg::OP_INSTALL;
    w.byte_offset[25:16]   = p[9:0];
    w.target_page          = p[15:0];
    if (slots_in_use() > 0 && $urandom_range(0, 99) < 85) begin
      w.chosen_slot = 16'($urandom_range(0, slots_in_use() - 1));
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Result side. The receiver idles at random, except during a steady
  // stretch, and holds off completely for StallCycles when asked to.
  // --------------------------------------------------------------------------
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_request) begin
        stall_request = 1'b0;
        out_if.ready <= 1'b0;
        repeat (StallCycles) @(negedge clk_i);
      end
      out_if.ready <= steady || ($urandom_range(0, 99) >= 17);
    end
  end

  task automatic check_field(string field, logic [25:0] want, logic [25:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  // Each result word taken is compared with the oldest owed result.
  ptti_pkg::out_word_t owed;
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (mapping_answers.size() == 0) begin
        $error("result word 0x%0h arrived with no request pending", out_if.payload);
        mismatches++;
      end else begin
        owed = mapping_answers.pop_front();
        check_field("status", 26'(owed.status), 26'(out_if.payload.status));
        check_field("window_offset", owed.window_offset, out_if.payload.window_offset);
        check_field("miss_page", 26'(owed.miss_page), 26'(out_if.payload.miss_page));
        check_field("result_slot", 26'(owed.result_slot),
                    26'(out_if.payload.result_slot));
        results_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Straight after reset both counts are zero, so every page is out of range.
  task automatic test_reset_state();
    send_access(translate_word(26'd0));
    send_access(translate_word(26'h3FFFFFF));
    send_access(install_word(16'd0, 16'd0));
  endtask

  // Identity mode: pages map onto themselves and installs leave the maps
  // alone. A page count above the map size is clipped to the map size.
  task automatic test_identity_mode();
    apply_setting(1'b0, 11'h7FF, 11'd0);
    send_access(translate_word(26'd0));
    send_access(translate_word(26'h3FFFFFF));
    send_access(install_word(16'd1023, 16'hFFFF));
    send_access(install_word(16'd1024, 16'd0));
    send_access(install_word(16'hFFFF, 16'hFFFF));
    apply_setting(1'b0, 11'd5, 11'd0);
    send_access(translate_word({10'd5, 16'h1234}));
    send_access(translate_word({10'd4, 16'hFFFF}));
  endtask

  // Paging mode: a miss, the install that fixes it, bad slots, a victim page
  // losing its slot, and a page moved to a second slot.
  task automatic test_paging_faults();
    apply_setting(1'b1, 11'd1024, 11'd256);
    send_access(translate_word({10'd7, 16'h0000}));
    send_access(install_word(16'd7, 16'd255));
    send_access(translate_word({10'd7, 16'hFFFF}));
    send_access(install_word(16'd8, 16'd256));
    send_access(install_word(16'd8, 16'hFFFF));
    send_access(install_word(16'd1023, 16'd0));
    send_access(translate_word({10'd1023, 16'h0000}));
    // Slot 255 passes from page 7 to page 9.
    send_access(install_word(16'd9, 16'd255));
    send_access(translate_word({10'd7, 16'h8001}));
    // Page 9 moves to slot 3; slot 255 still points back at it.
    send_access(install_word(16'd9, 16'd3));
    send_access(translate_word({10'd9, 16'h5A5A}));
    // Reusing slot 255 therefore drops page 9 as well.
    send_access(install_word(16'd10, 16'd255));
    send_access(translate_word({10'd9, 16'hA5A5}));
    send_access(install_word(16'd1024, 16'd0));
  endtask

  // A mapping made under a large slot count survives when the count is
  // lowered; zero slots reject every install and zero pages every access.
  task automatic test_stale_slot();
    send_access(install_word(16'd20, 16'd200));
    apply_setting(1'b1, 11'd1024, 11'd16);
    send_access(translate_word({10'd20, 16'hABCD}));
    send_access(install_word(16'd21, 16'd16));
    apply_setting(1'b1, 11'd1024, 11'd0);
    send_access(install_word(16'd21, 16'd0));
    apply_setting(1'b1, 11'd0, 11'd256);
    send_access(translate_word({10'd20, 16'h0001}));
  endtask

  // Random phases, each under its own register setting. A translate that
  // misses is often followed by the install a fault handler would issue and
  // by the same translate again.
  task automatic test_random_traffic();
    ptti_pkg::in_word_t w;
    ptti_pkg::in_word_t fix;
    logic [10:0]        pages;
    logic [10:0]        slots;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case ($urandom_range(0, 7))
        0:       pages = 11'd0;
        1:       pages = 11'd1;
        2:       pages = 11'd1024;
        3:       pages = 11'h7FF;
        4:       pages = 11'($urandom_range(0, 2047));
        default: pages = 11'($urandom_range(2, 64));
      endcase
      case ($urandom_range(0, 7))
        0:       slots = 11'd0;
        1:       slots = 11'd1;
        2:       slots = 11'd256;
        3:       slots = 11'd511;
        4:       slots = 11'($urandom_range(0, 511));
        default: slots = 11'($urandom_range(2, 32));
      endcase
      // The first two phases pin the largest and the smallest useful sizes.
      if (phase == 0) begin
        pages = 11'h7FF;
        slots = 11'd511;
      end else if (phase == 1) begin
        pages = 11'd1;
        slots = 11'd1;
      end
      apply_setting((phase < 2) || ($urandom_range(0, 9) < 7), pages, slots);
      steady = (phase == 3);
      if (phase == 5 || phase == 9) stall_request = 1'b1;
      for (int n = 0; n < PhaseWords; n++) begin
        w = random_access();
        send_access(w);
        if (last_answer.status == ptti_pkg::ST_MISS && $urandom_range(0, 99) < 60) begin
          fix = install_word({6'd0, last_answer.miss_page}, 16'($urandom));
          if (slots_in_use() > 0) fix.chosen_slot = 16'($urandom_range(0, slots_in_use() - 1));
          send_access(fix);
          send_access(w);
        end
      end
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run.
  // --------------------------------------------------------------------------
  initial begin
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    steady         = 1'b0;
    stall_request  = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The first word waits on in_i.ready, which stays low while the block
    // clears its maps after reset.
    test_reset_state();
    test_identity_mode();
    test_paging_faults();
    test_stale_slot();
    test_random_traffic();

    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d words under %0d register settings; %0d results checked, %0d mismatches.",
             words_sent, settings_used, results_checked, mismatches);
    $display("Outcomes: %0d ok, %0d miss, %0d page out of range, %0d invalid slot.",
             status_tally[ptti_pkg::ST_OK], status_tally[ptti_pkg::ST_MISS],
             status_tally[ptti_pkg::ST_RANGE], status_tally[ptti_pkg::ST_SLOT]);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("Timeout with %0d results still owed.", mapping_answers.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ptti_pkg.sv
hw/rtl/ptti_if.sv
hw/rtl/ptti_ram.sv
hw/rtl/page_table_translate_and_install.sv
tb/sv/tb.sv
